/* design/pbv_pkg.sv */
// Package for the packed bit vector block: field widths, operation and status
// codes, controller states and the command/status structs.
// No dependencies.
package pbv_pkg;

   localparam int OP_W  = 3;
   localparam int POS_W = 11;
   localparam int LEN_W = 11;
   localparam int ST_W  = 2;

   typedef enum logic [OP_W-1:0] {
      OP_APPEND      = 3'd0,
      OP_READ        = 3'd1,
      OP_WRITE       = 3'd2,
      OP_INSERT      = 3'd3,
      OP_ERASE_ONE   = 3'd4,
      OP_ERASE_RANGE = 3'd5
   } pbv_op_type;

   typedef enum logic [ST_W-1:0] {
      ST_OK      = 2'd0,
      ST_INVALID = 2'd1,
      ST_FULL    = 2'd2
   } pbv_status_type;

   // what the decoded request still needs after its first step
   typedef enum logic [1:0] {
      PLAN_NONE,
      PLAN_READ,
      PLAN_SHIFT
   } pbv_plan_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_EXEC,
      S_RDWAIT,
      S_SHIFT,
      S_DRAIN,
      S_FINISH,
      S_DONE
   } pbv_state_type;

   typedef struct packed {
      logic load;
      logic exec;
      logic rd_cap;
      logic shift;
      logic finish;
      logic rsp_load;
   } pbv_cmd_type;

   typedef struct packed {
      pbv_plan_type plan;
      logic         last_move;
      logic         rsp_busy;
   } pbv_sts_type;

endpackage

/* design/pbv_if.sv */
// Valid/ready channel interfaces for requests and results.
// Depends on pbv_pkg for the field widths.
interface pbv_req_if import pbv_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [OP_W-1:0]  operation;
   logic [POS_W-1:0] position;
   logic [POS_W-1:0] range_end;
   logic             bit_value;

   modport source (output valid, operation, position, range_end, bit_value, input ready);
   modport sink   (input valid, operation, position, range_end, bit_value, output ready);
endinterface

interface pbv_rsp_if import pbv_pkg::*; ();
   logic             valid;
   logic             ready;
   logic             read_bit;
   logic [LEN_W-1:0] length;
   logic [ST_W-1:0]  status;

   modport source (output valid, read_bit, length, status, input ready);
   modport sink   (input valid, read_bit, length, status, output ready);
endinterface

/* design/pbv_datapath.sv */
// Datapath: operand registers, length register, bit memory with registered
// read, shift address counters and the result register. Depends on pbv_pkg.
module pbv_datapath import pbv_pkg::*; #(
   parameter int CAPACITY = 1024
) (
   input  logic             clock,
   input  logic             reset,
   input  pbv_cmd_type      cmd,
   output pbv_sts_type      sts,
   input  logic [OP_W-1:0]  in_operation,
   input  logic [POS_W-1:0] in_position,
   input  logic [POS_W-1:0] in_range_end,
   input  logic             in_bit_value,
   output logic             out_valid,
   input  logic             out_ready,
   output logic             out_read_bit,
   output logic [LEN_W-1:0] out_length,
   output logic [ST_W-1:0]  out_status
);

   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int AW    = $clog2(CAPACITY);
   localparam int W     = (CNT_W > POS_W) ? CNT_W : POS_W;

   logic                mem [CAPACITY];
   logic                rdata_ff;

   logic [OP_W-1:0]     op_ff;
   logic [W-1:0]        pos_ff, end_ff;
   logic                val_ff;
   logic [CNT_W-1:0]    count_ff, count_in;
   pbv_status_type      st_ff, st_in;
   logic                rbit_ff, rbit_in;
   logic [AW-1:0]       src_ff, src_in, dst_ff, dst_in, stop_ff, stop_in;
   logic                up_ff, up_in;
   logic [CNT_W-1:0]    gap_ff, gap_in;
   logic                pend_ff;
   logic [AW-1:0]       pend_dst_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_bit_ff;
   logic [LEN_W-1:0]    rsp_len_ff;
   pbv_status_type      rsp_st_ff;

   logic [W-1:0]        cnt_w, cap_w, erase_end, gap_w;
   pbv_plan_type        plan;
   logic                exec_we;
   logic [AW-1:0]       exec_addr;
   logic                we, wdata;
   logic [AW-1:0]       waddr, raddr;

   assign cnt_w     = W'(count_ff);
   assign cap_w     = W'(CAPACITY);
   assign erase_end = (op_ff == OP_ERASE_ONE) ? pos_ff + W'(1) : end_ff;
   assign gap_w     = erase_end - pos_ff;

   // decode of the held request against the current length
   always_comb begin
      plan      = PLAN_NONE;
      st_in     = st_ff;
      rbit_in   = rbit_ff;
      count_in  = count_ff;
      src_in    = src_ff;
      dst_in    = dst_ff;
      stop_in   = stop_ff;
      up_in     = up_ff;
      gap_in    = gap_ff;
      exec_we   = 1'b0;
      exec_addr = pos_ff[AW-1:0];
      if (cmd.exec) begin
         st_in   = ST_OK;
         rbit_in = 1'b0;
         case (op_ff)
            OP_APPEND: begin
               if (cnt_w == cap_w) begin
                  st_in = ST_FULL;
               end else begin
                  exec_we   = 1'b1;
                  exec_addr = count_ff[AW-1:0];
                  count_in  = count_ff + CNT_W'(1);
               end
            end
            OP_READ: begin
               if (pos_ff >= cnt_w) st_in = ST_INVALID;
               else plan = PLAN_READ;
            end
            OP_WRITE: begin
               if (pos_ff >= cnt_w) st_in = ST_INVALID;
               else exec_we = 1'b1;
            end
            OP_INSERT: begin
               if (pos_ff > cnt_w) begin
                  st_in = ST_INVALID;
               end else if (cnt_w == cap_w) begin
                  st_in = ST_FULL;
               end else if (pos_ff == cnt_w) begin
                  exec_we  = 1'b1;
                  count_in = count_ff + CNT_W'(1);
               end else begin
                  plan    = PLAN_SHIFT;
                  up_in   = 1'b1;
                  src_in  = count_ff[AW-1:0] - AW'(1);
                  dst_in  = count_ff[AW-1:0];
                  stop_in = pos_ff[AW-1:0];
               end
            end
            OP_ERASE_ONE, OP_ERASE_RANGE: begin
               if ((op_ff == OP_ERASE_ONE && pos_ff >= cnt_w) ||
                   (op_ff == OP_ERASE_RANGE && (pos_ff > end_ff || end_ff > cnt_w))) begin
                  st_in = ST_INVALID;
               end else if (erase_end == cnt_w || gap_w == '0) begin
                  // tail erase or empty range: nothing to move
                  count_in = count_ff - gap_w[CNT_W-1:0];
               end else begin
                  plan    = PLAN_SHIFT;
                  up_in   = 1'b0;
                  gap_in  = gap_w[CNT_W-1:0];
                  src_in  = erase_end[AW-1:0];
                  dst_in  = pos_ff[AW-1:0];
                  stop_in = count_ff[AW-1:0] - AW'(1);
               end
            end
            default: st_in = ST_INVALID;
         endcase
      end
      if (cmd.shift) begin
         src_in = up_ff ? src_ff - AW'(1) : src_ff + AW'(1);
         dst_in = up_ff ? dst_ff - AW'(1) : dst_ff + AW'(1);
      end
      if (cmd.finish) begin
         count_in = up_ff ? count_ff + CNT_W'(1) : count_ff - gap_ff;
      end
      if (cmd.rd_cap) begin
         rbit_in = rdata_ff;
      end
   end

   // one bit moves per cycle: read at src, write the returned bit in the next cycle
   assign we    = pend_ff | exec_we | (cmd.finish & up_ff);
   assign waddr = pend_ff ? pend_dst_ff : (cmd.finish ? pos_ff[AW-1:0] : exec_addr);
   assign wdata = pend_ff ? rdata_ff : val_ff;
   assign raddr = cmd.shift ? src_ff : pos_ff[AW-1:0];

   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      rdata_ff <= mem[raddr];
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_ready) rsp_valid_in = 1'b0;
      if (cmd.rsp_load) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         pend_ff      <= cmd.shift;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff  <= in_operation;
         pos_ff <= W'(in_position);
         end_ff <= W'(in_range_end);
         val_ff <= in_bit_value;
      end
      st_ff       <= st_in;
      rbit_ff     <= rbit_in;
      src_ff      <= src_in;
      dst_ff      <= dst_in;
      stop_ff     <= stop_in;
      up_ff       <= up_in;
      gap_ff      <= gap_in;
      pend_dst_ff <= dst_ff;
      if (cmd.rsp_load) begin
         rsp_bit_ff <= rbit_ff;
         rsp_len_ff <= LEN_W'(count_ff);
         rsp_st_ff  <= st_ff;
      end
   end

   assign sts.plan      = plan;
   assign sts.last_move = (src_ff == stop_ff);
   assign sts.rsp_busy  = rsp_valid_ff & ~out_ready;

   assign out_valid    = rsp_valid_ff;
   assign out_read_bit = rsp_bit_ff;
   assign out_length   = rsp_len_ff;
   assign out_status   = rsp_st_ff;

endmodule

/* design/pbv_ctrl.sv */
// Controller state machine: sequences accept, decode, read, bit moves and
// result load. Depends on pbv_pkg.
module pbv_ctrl import pbv_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  pbv_sts_type sts,
   output pbv_cmd_type cmd
);

   pbv_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else state_ff <= state_in;
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            cmd.exec = 1'b1;
            case (sts.plan)
               PLAN_READ:  state_in = S_RDWAIT;
               PLAN_SHIFT: state_in = S_SHIFT;
               default:    state_in = S_DONE;
            endcase
         end
         S_RDWAIT: begin
            cmd.rd_cap = 1'b1;
            state_in   = S_DONE;
         end
         S_SHIFT: begin
            cmd.shift = 1'b1;
            if (sts.last_move) state_in = S_DRAIN;
         end
         S_DRAIN: state_in = S_FINISH;  // last moved bit lands here
         S_FINISH: begin
            cmd.finish = 1'b1;
            state_in   = S_DONE;
         end
         S_DONE: begin
            if (!sts.rsp_busy) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

endmodule

/* design/packed_bit_vector_insert_erase_core.sv */
// Packed bit vector with append, read, write, insert and erase: a one-bit-wide
// memory of CAPACITY entries and a length register, with one result per
// request. Append, write, any rejected request and any insert or erase that
// moves no bits finish at decode; a read adds a capture of the registered
// memory read. Other inserts and erases move one bit per cycle through the
// memory's read and write ports (read, then write in the next cycle), then write
// any inserted bit and update the length. One request is worked at a time; a
// finished result sits in the output register while the next request is
// taken. The memory has no reset: only written positions are ever read back.
module packed_bit_vector_insert_erase_core import pbv_pkg::*; #(
   parameter int CAPACITY = 1024
) (
   input logic         clock,
   input logic         reset,
   pbv_req_if.sink     req_ch,
   pbv_rsp_if.source   rsp_ch
);

   pbv_cmd_type cmd;
   pbv_sts_type sts;

   pbv_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   pbv_datapath #(.CAPACITY(CAPACITY)) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .sts          (sts),
      .in_operation (req_ch.operation),
      .in_position  (req_ch.position),
      .in_range_end (req_ch.range_end),
      .in_bit_value (req_ch.bit_value),
      .out_valid    (rsp_ch.valid),
      .out_ready    (rsp_ch.ready),
      .out_read_bit (rsp_ch.read_bit),
      .out_length   (rsp_ch.length),
      .out_status   (rsp_ch.status)
   );

   // a full report can only come from a vector holding every bit
   a_full_len: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.status == ST_FULL |-> rsp_ch.length == LEN_W'(CAPACITY))
      else $error("full status with length below capacity");

   a_read_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.read_bit |-> rsp_ch.status == ST_OK)
      else $error("read bit set on a failed request");

   // one request in work at a time
   a_one_req: assert property (@(posedge clock) disable iff (reset)
      req_ch.valid && req_ch.ready |=> !req_ch.ready)
      else $error("request taken while another is in work");

endmodule

/* sim/testbench.sv */
// Testbench for packed_bit_vector_insert_erase_core: directed and random requests on
// the request channel, with each response checked against a bit-level predictor.
// Depends on pbv_pkg, the pbv_req_if/pbv_rsp_if interfaces and the core itself.
module testbench;
   import pbv_pkg::*;

   localparam int CAPACITY     = 1024;
   localparam int IDLE_PCT     = 33;
   localparam int STALL_AT     = 60;     // response count at which the long hold-off starts
   localparam int STALL_CYCLES = 300;
   localparam int STEADY_FROM  = 120;    // request transfers without idling on either side
   localparam int STEADY_TO    = 220;
   localparam int QUIET_LIMIT  = 6000;
   localparam int TAIL_CYCLES  = 16;

   // operation codes the block does not define
   localparam logic [OP_W-1:0] OP_SPARE_6 = 3'd6;
   localparam logic [OP_W-1:0] OP_SPARE_7 = 3'd7;

   typedef struct {
      logic [OP_W-1:0]  op;
      logic [POS_W-1:0] pos;
      logic [POS_W-1:0] rend;
      logic             bval;
      bit               drain_first;
   } req_item_type;

   typedef struct packed {
      logic             read_bit;
      logic [LEN_W-1:0] length;
      logic [ST_W-1:0]  status;
   } bitvec_rsp_type;

   logic clock;
   logic reset;

   pbv_req_if req_ch ();
   pbv_rsp_if rsp_ch ();

   packed_bit_vector_insert_erase_core #(
      .CAPACITY (CAPACITY)
   ) uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   req_item_type   pending_items[$];
   bitvec_rsp_type due_results[$];
   req_item_type   offered;

   bit          vec_bits [CAPACITY];
   int unsigned vec_len;

   int unsigned plan_len;
   bit          pause_next;
   int          req_sent;
   int          results_seen;
   int          stall_left;
   int          quiet_cycles;
   int          fail_count;
   logic        steady;

   assign steady = (req_sent >= STEADY_FROM) && (req_sent < STEADY_TO);

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Bit-level view of the vector: applies one request, returns its response.
   function automatic bitvec_rsp_type bitvec_step(input req_item_type it);
      bitvec_rsp_type r;
      int unsigned p, e, gap, k;
      r.read_bit = 1'b0;
      r.status   = ST_OK;
      p = 32'(it.pos);
      e = 32'(it.rend);
      case (it.op)
         OP_APPEND: begin
            if (vec_len >= CAPACITY) begin
               r.status = ST_FULL;
            end else begin
               vec_bits[vec_len] = it.bval;
               vec_len++;
            end
         end
         OP_READ: begin
            if (p >= vec_len) r.status = ST_INVALID;
            else r.read_bit = vec_bits[p];
         end
         OP_WRITE: begin
            if (p >= vec_len) r.status = ST_INVALID;
            else vec_bits[p] = it.bval;
         end
         OP_INSERT: begin
            // a bad position wins over a full vector
            if (p > vec_len) begin
               r.status = ST_INVALID;
            end else if (vec_len >= CAPACITY) begin
               r.status = ST_FULL;
            end else begin
               for (k = vec_len; k > p; k--) vec_bits[k] = vec_bits[k-1];
               vec_bits[p] = it.bval;
               vec_len++;
            end
         end
         OP_ERASE_ONE: begin
            if (p >= vec_len) begin
               r.status = ST_INVALID;
            end else begin
               for (k = p; k + 1 < vec_len; k++) vec_bits[k] = vec_bits[k+1];
               vec_len--;
            end
         end
         OP_ERASE_RANGE: begin
            if (p > e || e > vec_len) begin
               r.status = ST_INVALID;
            end else begin
               gap = e - p;
               for (k = e; k < vec_len; k++) vec_bits[k-gap] = vec_bits[k];
               vec_len -= gap;
            end
         end
         default: r.status = ST_INVALID;
      endcase
      r.length = vec_len[LEN_W-1:0];
      return r;
   endfunction

   // Stimulus side keeps its own idea of the length so positions land near it.
   task automatic queue_item(input logic [OP_W-1:0] op, input logic [POS_W-1:0] p,
                             input logic [POS_W-1:0] e, input logic b);
      req_item_type it;
      it.op          = op;
      it.pos         = p;
      it.rend        = e;
      it.bval        = b;
      it.drain_first = pause_next;
      pause_next     = 1'b0;
      pending_items.insert(pending_items.size(), it);
      case (op)
         OP_APPEND:      if (plan_len < CAPACITY) plan_len++;
         OP_INSERT:      if (p <= plan_len && plan_len < CAPACITY) plan_len++;
         OP_ERASE_ONE:   if (p < plan_len) plan_len--;
         OP_ERASE_RANGE: if (p <= e && e <= plan_len) plan_len -= (e - p);
         default: ;
      endcase
   endtask

   function automatic logic [POS_W-1:0] rand_pos(input int unsigned len);
      int unsigned r;
      r = $urandom_range(0, 99);
      if (len > 0 && r < 80) return POS_W'($urandom_range(0, len - 1));
      else if (r < 88) return POS_W'(len);
      else if (r < 95) return POS_W'($urandom_range(len, 2047));
      else return POS_W'($urandom_range(0, 2047));
   endfunction

   task automatic queue_random(input bit grow);
      int unsigned r, s, lim;
      logic [OP_W-1:0]  op;
      logic [POS_W-1:0] p, e;
      r = $urandom_range(0, 99);
      if (grow) begin
         if (r < 28)      op = OP_APPEND;
         else if (r < 55) op = OP_INSERT;
         else if (r < 70) op = OP_READ;
         else if (r < 82) op = OP_WRITE;
         else if (r < 90) op = OP_ERASE_ONE;
         else if (r < 98) op = OP_ERASE_RANGE;
         else             op = $urandom_range(0, 1) ? OP_SPARE_6 : OP_SPARE_7;
      end else begin
         if (r < 14)      op = OP_APPEND;
         else if (r < 32) op = OP_INSERT;
         else if (r < 50) op = OP_READ;
         else if (r < 64) op = OP_WRITE;
         else if (r < 80) op = OP_ERASE_ONE;
         else if (r < 95) op = OP_ERASE_RANGE;
         else             op = $urandom_range(0, 1) ? OP_SPARE_6 : OP_SPARE_7;
      end
      p = rand_pos(plan_len);
      e = POS_W'($urandom_range(0, 2047));
      if (op == OP_ERASE_RANGE) begin
         r = $urandom_range(0, 99);
         if (r < 85) begin
            s   = $urandom_range(0, plan_len);
            lim = (plan_len - s < 12) ? plan_len - s : 12;
            p   = POS_W'(s);
            e   = POS_W'(s + $urandom_range(0, lim));
         end else if (r < 90) begin
            s = $urandom_range(0, plan_len);
            p = POS_W'(s);
            e = POS_W'($urandom_range(s, plan_len));
         end else if (r < 95) begin
            // reversed range
            s = $urandom_range(1, 2047);
            p = POS_W'(s);
            e = POS_W'($urandom_range(0, s - 1));
         end else begin
            p = POS_W'($urandom_range(0, plan_len));
            e = POS_W'($urandom_range(plan_len + 1, 2047));
         end
      end
      queue_item(op, p, e, 1'($urandom_range(0, 1)));
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            due_results.insert(due_results.size(), bitvec_step(offered));
            req_sent <= req_sent + 1;
         end
         if (!req_ch.valid || req_ch.ready) begin
            if (pending_items.size() != 0
                && !(pending_items[0].drain_first && due_results.size() != 0)
                && (steady || $urandom_range(0, 99) >= IDLE_PCT)) begin
               offered = pending_items.pop_front();
               req_ch.valid     <= 1'b1;
               req_ch.operation <= offered.op;
               req_ch.position  <= offered.pos;
               req_ch.range_end <= offered.rend;
               req_ch.bit_value <= offered.bval;
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // response monitor and checker
   always @(posedge clock) begin
      bitvec_rsp_type want;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (due_results.size() == 0) begin
               $error("response transfer with no request outstanding");
               fail_count++;
            end else begin
               want = due_results.pop_front();
               if (rsp_ch.read_bit !== want.read_bit) begin
                  $error("read_bit mismatch: expected %0d, got %0d", want.read_bit,
                         rsp_ch.read_bit);
                  fail_count++;
               end
               if (rsp_ch.length !== want.length) begin
                  $error("length mismatch: expected %0d, got %0d", want.length,
                         rsp_ch.length);
                  fail_count++;
               end
               if (rsp_ch.status !== want.status) begin
                  $error("status mismatch: expected %0d, got %0d", want.status,
                         rsp_ch.status);
                  fail_count++;
               end
            end
            results_seen++;
            if (results_seen == STALL_AT) stall_left = STALL_CYCLES;
         end
         // long hold-off so the core backs up and stalls its input
         if (stall_left > 0) begin
            stall_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == QUIET_LIMIT) begin
         $display("status: fail");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      int i;
      reset            = 1'b1;
      req_ch.valid     = 1'b0;
      req_ch.operation = OP_APPEND;
      req_ch.position  = '0;
      req_ch.range_end = '0;
      req_ch.bit_value = 1'b0;
      rsp_ch.ready     = 1'b0;
      vec_len          = 0;
      plan_len         = 0;
      pause_next       = 1'b0;
      req_sent         = 0;
      results_seen     = 0;
      stall_left       = 0;
      quiet_cycles     = 0;
      fail_count       = 0;

      // directed: empty vector first, then a handful of bits
      queue_item(OP_READ,        0, 0, 0);
      queue_item(OP_ERASE_ONE,   0, 0, 0);
      queue_item(OP_ERASE_RANGE, 0, 0, 0);      // empty range is fine
      queue_item(OP_ERASE_RANGE, 0, 1, 0);      // end past the length
      queue_item(OP_INSERT,      1, 0, 1);
      queue_item(OP_WRITE,       0, 0, 1);
      queue_item(OP_INSERT,      0, 0, 1);      // insert into empty vector
      queue_item(OP_APPEND,      0, 0, 0);
      queue_item(OP_APPEND,      0, 0, 1);
      queue_item(OP_INSERT,      3, 0, 0);      // insert at the length appends
      queue_item(OP_INSERT,      1, 0, 1);
      queue_item(OP_READ,        1, 0, 0);
      queue_item(OP_READ,        4, 0, 0);
      queue_item(OP_READ,        5, 0, 0);
      queue_item(OP_WRITE,       0, 0, 0);
      queue_item(OP_WRITE,       5, 0, 1);
      queue_item(OP_ERASE_RANGE, 3, 1, 0);      // reversed range
      queue_item(OP_ERASE_ONE,   0, 0, 0);
      queue_item(OP_ERASE_RANGE, 1, 3, 0);
      queue_item(OP_SPARE_6,     0, 0, 1);
      queue_item(OP_SPARE_7,     0, 0, 1);
      queue_item(OP_READ,     2047, 2047, 1);
      queue_item(OP_INSERT,   1024, 0, 1);
      queue_item(OP_ERASE_RANGE, 0, 1024, 0);
      queue_item(OP_ERASE_ONE,   1, 0, 0);

      for (i = 0; i < 200; i++) queue_random(1'b1);

      // positions around the capacity, once the pipe has drained
      pause_next = 1'b1;
      queue_item(OP_APPEND,   0, 0, 1);
      queue_item(OP_INSERT,   1024, 0, 1);
      queue_item(OP_INSERT,   1025, 0, 0);
      queue_item(OP_INSERT,   5, 0, 0);
      queue_item(OP_READ,     1023, 0, 0);
      queue_item(OP_WRITE,    1023, 0, 1);
      queue_item(OP_READ,     1024, 0, 0);
      queue_item(OP_ERASE_RANGE, 1000, 1024, 0);
      for (i = 0; i < 150; i++) queue_random(1'b0);

      pause_next = 1'b1;
      if (plan_len > 40) queue_item(OP_ERASE_RANGE, 0, POS_W'(plan_len - 40), 0);
      for (i = 0; i < 200; i++) queue_random(1'b0);

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      while (pending_items.size() != 0 || req_ch.valid) @(posedge clock);
      while (due_results.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      if (fail_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

/* sim.f */
design/pbv_pkg.sv
design/pbv_if.sv
design/pbv_datapath.sv
design/pbv_ctrl.sv
design/packed_bit_vector_insert_erase_core.sv
sim/testbench.sv
